// ===== rtl/core/lidar_median_obstacle_stop_unit_defines.svh =====
// ----------------------------------------------------------------------------
// lidar median obstacle stop: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef LIDAR_MEDIAN_OBSTACLE_STOP_UNIT_DEFINES_SVH
`define LIDAR_MEDIAN_OBSTACLE_STOP_UNIT_DEFINES_SVH

// a condition that holds at every clock edge out of reset
`define LMOS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// an implication checked at every clock edge out of reset
`define LMOS_ASSERT_IMPL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== rtl/core/lmos_pkg.sv =====
// ----------------------------------------------------------------------------
// lmos_pkg
// Shared types and constants of the lidar median obstacle stop unit.
// ----------------------------------------------------------------------------
package lmos_pkg;

  // default sizes handed down from the top level
  localparam int WINDOW_DEFAULT      = 15;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // field widths
  localparam int DIST_W   = 16;
  localparam int FILT_W   = 17;
  localparam int BYTE_W   = 8;
  localparam int RUN_W    = 4;
  localparam int PHASE_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int M_DATA_W = 48;

  // frame format
  localparam logic [BYTE_W-1:0]  HEADER_BYTE = 8'h59;
  localparam logic [PHASE_W-1:0] PH_HUNT1    = 4'd0;
  localparam logic [PHASE_W-1:0] PH_HUNT2    = 4'd1;
  localparam logic [PHASE_W-1:0] PH_DIST_LO  = 4'd2;
  localparam logic [PHASE_W-1:0] PH_DIST_HI  = 4'd3;
  localparam logic [PHASE_W-1:0] PH_CHECK    = 4'd8;
  localparam logic [RUN_W-1:0]   RUN_MAX     = 4'd15;

  // input kinds on tuser
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REQUIRED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_DUTY  = 2'd2;

  // register reset values
  localparam logic [15:0] THRESHOLD_RESET = 16'd800;
  localparam logic [3:0]  REQUIRED_RESET  = 4'd5;
  localparam logic [7:0]  RUN_DUTY_RESET  = 8'd100;

  // command from the parser to the filter back end
  typedef struct packed {
    logic              clear;
    logic [DIST_W-1:0] distance;
  } cmd_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [15:0] threshold_cm;
    logic [3:0]  readings_required;
    logic [7:0]  run_duty;
  } cfg_t;

endpackage

// ===== rtl/core/lmos_parser.sv =====
// ----------------------------------------------------------------------------
// lmos_parser
// Frame parser: hunts the double header, gathers the distance and checksum,
// and queues a distance per good frame or a clear per timeout.
// ----------------------------------------------------------------------------
module lmos_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_op,
  input  logic [7:0]          in_byte,
  output logic                push,
  output lmos_pkg::cmd_t      push_cmd
);
  import lmos_pkg::*;

  logic [PHASE_W-1:0] phase;
  logic [BYTE_W-1:0]  frame_sum;
  logic [BYTE_W-1:0]  dist_low;
  logic [BYTE_W-1:0]  dist_high;

  // command toward the queue
  assign push_cmd.clear    = (in_op == OP_TIMEOUT);
  assign push_cmd.distance = {dist_high, dist_low};
  assign push = in_valid &&
                ((in_op == OP_TIMEOUT) ||
                 (phase == PH_CHECK && in_byte == frame_sum));

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT1;
      frame_sum <= '0;
    end else if (in_valid) begin
      if (in_op == OP_TIMEOUT) begin
        phase     <= PH_HUNT1;
        frame_sum <= '0;
      end else if (phase == PH_HUNT1) begin
        if (in_byte == HEADER_BYTE) phase <= PH_HUNT2;
      end else if (phase == PH_HUNT2) begin
        if (in_byte == HEADER_BYTE) begin
          phase     <= PH_DIST_LO;
          frame_sum <= HEADER_BYTE + HEADER_BYTE;
        end else begin
          phase <= PH_HUNT1;
        end
      end else if (phase < PH_CHECK) begin
        frame_sum <= frame_sum + in_byte;
        phase     <= phase + 1'b1;
      end else begin
        phase     <= PH_HUNT1;
        frame_sum <= '0;
      end
    end
  end

  // distance bytes
  always_ff @(posedge clk) begin
    if (in_valid && in_op == OP_BYTE) begin
      if (phase == PH_DIST_LO) dist_low  <= in_byte;
      if (phase == PH_DIST_HI) dist_high <= in_byte;
    end
  end

endmodule

// ===== rtl/core/lmos_queue.sv =====
// ----------------------------------------------------------------------------
// lmos_queue
// Small command fifo between the parser and the filter back end.
// ----------------------------------------------------------------------------
module lmos_queue #(
  parameter int DEPTH = lmos_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lmos_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           head_valid,
  output lmos_pkg::cmd_t head_cmd,
  input  logic           pop
);
  import lmos_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_cmd;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/core/lmos_median_back.sv =====
// ----------------------------------------------------------------------------
// lmos_median_back
// Back end: keeps the sample window and a sorted copy of it, takes the
// median, counts close readings and latches the stop.
// ----------------------------------------------------------------------------
`include "lidar_median_obstacle_stop_unit_defines.svh"

module lmos_median_back #(
  parameter int WINDOW = lmos_pkg::WINDOW_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  lmos_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  lmos_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [15:0]    out_raw,
  output logic [16:0]    out_filt,
  output logic           out_close,
  output logic [3:0]     out_run,
  output logic           out_stop,
  output logic [7:0]     out_pwm
);
  import lmos_pkg::*;

  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REMOVE = 3'd1;
  localparam logic [2:0] ST_INSERT = 3'd2;
  localparam logic [2:0] ST_MED_A  = 3'd3;
  localparam logic [2:0] ST_MED_B  = 3'd4;
  localparam logic [2:0] ST_DECIDE = 3'd5;

  logic [2:0]        state;
  logic [DIST_W-1:0] win    [WINDOW];
  logic [DIST_W-1:0] sorted [WINDOW];
  logic [DIST_W-1:0] rem_val [WINDOW];
  logic [DIST_W-1:0] ins_val [WINDOW];
  logic [WINDOW-1:0] lt;
  logic [IW-1:0]     wslot;
  logic [CW-1:0]     sort_n;
  logic [RUN_W-1:0]  close_count;
  logic              halted;
  logic [DIST_W-1:0] raw;
  logic [DIST_W-1:0] old;
  logic [DIST_W-1:0] key;
  logic [DIST_W-1:0] med_a;
  logic [FILT_W-1:0] filt;
  logic [IW-1:0]     half;
  logic [IW-1:0]     rd_idx;
  logic [DIST_W-1:0] rd_val;
  logic              odd;
  logic              close;
  logic [RUN_W-1:0]  count_next;
  logic              stop_next;
  logic              out_free;

  // sorted-list lane compare against the value being removed or inserted
  assign key = (state == ST_REMOVE) ? old : raw;

  genvar k;
  generate
    for (k = 0; k < WINDOW; k++) begin : g_lane
      assign lt[k] = (CW'(k) < sort_n) && (sorted[k] < key);
      if (k == WINDOW - 1) begin : g_top
        assign rem_val[k] = sorted[k];
      end else begin : g_mid
        assign rem_val[k] = lt[k] ? sorted[k] : sorted[k+1];
      end
      if (k == 0) begin : g_bot
        assign ins_val[k] = lt[k] ? sorted[k] : key;
      end else begin : g_up
        assign ins_val[k] = lt[k] ? sorted[k] : (lt[k-1] ? key : sorted[k-1]);
      end
      // shift the lane on remove and insert
      always_ff @(posedge clk) begin
        if (state == ST_REMOVE)      sorted[k] <= rem_val[k];
        else if (state == ST_INSERT) sorted[k] <= ins_val[k];
      end
    end
  endgenerate

  // median read port, low middle then high middle
  assign odd    = sort_n[0];
  assign half   = IW'(sort_n >> 1);
  assign rd_idx = (state == ST_MED_A && !odd) ? half - 1'b1 : half;
  assign rd_val = sorted[rd_idx];

  // close decision for the finished median
  assign close      = (filt != '0) && (filt <= {1'b0, cfg.threshold_cm, 1'b0});
  assign count_next = !close ? '0 :
                      (close_count == RUN_MAX) ? RUN_MAX : close_count + 1'b1;
  assign stop_next  = halted || (count_next >= cfg.readings_required);
  assign out_free   = !out_valid || out_ready;
  assign q_pop      = (state == ST_IDLE) && q_valid;

  // circular sample window
  always_ff @(posedge clk) begin
    if (q_pop && !halted && !q_cmd.clear) begin
      win[wslot] <= q_cmd.distance;
      old        <= win[wslot];
      raw        <= q_cmd.distance;
    end
  end

  // median datapath
  always_ff @(posedge clk) begin
    if (state == ST_MED_A) med_a <= rd_val;
    if (state == ST_MED_B) begin
      filt <= odd ? {rd_val, 1'b0} : {1'b0, med_a} + {1'b0, rd_val};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      wslot       <= '0;
      sort_n      <= '0;
      close_count <= '0;
      halted      <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_pop && !halted) begin
            if (q_cmd.clear) begin
              close_count <= '0;
            end else begin
              wslot <= (wslot == IW'(WINDOW - 1)) ? '0 : wslot + 1'b1;
              state <= (sort_n == CW'(WINDOW)) ? ST_REMOVE : ST_INSERT;
            end
          end
        end
        ST_REMOVE: begin
          sort_n <= sort_n - 1'b1;
          state  <= ST_INSERT;
        end
        ST_INSERT: begin
          sort_n <= sort_n + 1'b1;
          state  <= ST_MED_A;
        end
        ST_MED_A: state <= ST_MED_B;
        ST_MED_B: state <= ST_DECIDE;
        ST_DECIDE: begin
          if (out_free) begin
            close_count <= count_next;
            halted      <= stop_next;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DECIDE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DECIDE && out_free) begin
      out_raw   <= raw;
      out_filt  <= filt;
      out_close <= close;
      out_run   <= count_next;
      out_stop  <= stop_next;
      out_pwm   <= stop_next ? '0 : cfg.run_duty;
    end
  end

  // checks
  `LMOS_ASSERT_ALWAYS(a_sort_n_range, sort_n <= CW'(WINDOW), "sorted count exceeds window")
  `LMOS_ASSERT_IMPL(a_halt_sticky, halted |=> halted, "stop latch released")
  `LMOS_ASSERT_IMPL(a_remove_full, (state == ST_REMOVE) |-> (sort_n == CW'(WINDOW)),
                    "eviction without a full window")
  `LMOS_ASSERT_IMPL(a_stop_zero_duty, (out_valid && out_stop) |-> (out_pwm == '0),
                    "stopped result with nonzero duty")

endmodule

// ===== rtl/core/lidar_median_obstacle_stop_unit.sv =====
// ----------------------------------------------------------------------------
// lidar_median_obstacle_stop_unit
// Lidar frame parser with a sliding-window median filter and obstacle stop.
// ----------------------------------------------------------------------------
// Input: one byte or timeout transaction per cycle while the command fifo has room.
// Back end: per good frame, evict (once the window is full), insert, two median
//   reads and decide, which waits for a free output register; it pops no command
//   until decide is done. A frame spans 9 input bytes; the result is registered.
// Reset: synchronous rst clears parser, fifo, counts and stop latch and loads
//   the register defaults; window contents are not cleared, only the held count.
module lidar_median_obstacle_stop_unit #(
  parameter int WINDOW      = lmos_pkg::WINDOW_DEFAULT,
  parameter int QUEUE_DEPTH = lmos_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] op
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [15:0] raw_distance, [32:16] filtered_half_cm,
                                 // [33] close_flag, [37:34] close_run,
                                 // [38] stop_latched, [46:39] pwm_duty, [47] zero
  // register writes
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import lmos_pkg::*;

  cfg_t         cfg;
  logic         in_valid;
  logic         push;
  cmd_t         push_cmd;
  logic         q_full;
  logic         q_valid;
  cmd_t         q_cmd;
  logic         q_pop;
  logic [15:0]  out_raw;
  logic [16:0]  out_filt;
  logic         out_close;
  logic [3:0]   out_run;
  logic         out_stop;
  logic [7:0]   out_pwm;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_cm      <= THRESHOLD_RESET;
      cfg.readings_required <= REQUIRED_RESET;
      cfg.run_duty          <= RUN_DUTY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_THRESHOLD: cfg.threshold_cm      <= cfg_data;
        REG_REQUIRED:  cfg.readings_required <= cfg_data[3:0];
        REG_RUN_DUTY:  cfg.run_duty          <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input handshake
  assign s_tready = !q_full;
  assign in_valid = s_tvalid && s_tready;

  lmos_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (s_tuser),
    .in_byte  (s_tdata),
    .push     (push),
    .push_cmd (push_cmd)
  );

  lmos_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (q_valid),
    .head_cmd   (q_cmd),
    .pop        (q_pop)
  );

  lmos_median_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_raw   (out_raw),
    .out_filt  (out_filt),
    .out_close (out_close),
    .out_run   (out_run),
    .out_stop  (out_stop),
    .out_pwm   (out_pwm)
  );

  // result packing
  assign m_tdata = {1'b0, out_pwm, out_stop, out_run, out_close, out_filt, out_raw};

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: lidar median obstacle stop unit testbench
// Drives lidar byte and timeout transactions into the unit and checks every
// result transaction against an in-bench model of the frame parser, the
// median window and the stop latch. Registers are changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import lmos_pkg::*;

  localparam int WIN             = WINDOW_DEFAULT;
  localparam int IDLE_PCT        = 17;
  localparam int SETTLE_CYCLES   = 48;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PHASE_ITEMS     = 135;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // one result transaction, highest field first
  typedef struct packed {
    logic [7:0]  pwm_duty;
    logic        stop_latched;
    logic [3:0]  close_run;
    logic        close_flag;
    logic [16:0] filtered_half_cm;
    logic [15:0] raw_distance;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] rx_byte
  logic        s_tuser = 1'b0; // [0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // [15:0] raw_distance, [32:16] filtered_half_cm,
                               // [33] close_flag, [37:34] close_run,
                               // [38] stop_latched, [46:39] pwm_duty
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // model copy of the registers
  logic [15:0] threshold_cfg = THRESHOLD_RESET;
  logic [3:0]  required_cfg  = REQUIRED_RESET;
  logic [7:0]  duty_cfg      = RUN_DUTY_RESET;

  // model copy of the parser, window and stop state
  logic [3:0]  parse_phase   = PH_HUNT1;
  logic [7:0]  parse_sum     = '0;
  logic [7:0]  dist_lo       = '0;
  logic [7:0]  dist_hi       = '0;
  logic [15:0] window_dist [WIN];
  int          window_slot   = 0;
  int          window_fill   = 0;
  logic [3:0]  close_run_now = '0;
  bit          stopped       = 1'b0;

  reading_t    expected_readings[$];
  int          mismatches    = 0;
  int          sent_items    = 0;
  int          quiet_cycles  = 0;
  bit          src_steady    = 1'b0;
  bit          sink_steady   = 1'b0;

  lidar_median_obstacle_stop_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock, 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model of one accepted input transaction
  task automatic predict_reading(input logic op, input logic [7:0] b);
    int          sorted_q[$];
    int          k;
    logic [16:0] median;
    logic        near;
    reading_t    r;
    if (stopped) return;
    if (op == OP_TIMEOUT) begin
      parse_phase   = PH_HUNT1;
      parse_sum     = '0;
      close_run_now = '0;
      return;
    end
    case (parse_phase)
      PH_HUNT1: begin
        if (b == HEADER_BYTE) parse_phase = PH_HUNT2;
      end
      PH_HUNT2: begin
        if (b == HEADER_BYTE) begin
          parse_phase = PH_DIST_LO;
          parse_sum   = HEADER_BYTE + HEADER_BYTE;
        end else begin
          parse_phase = PH_HUNT1;
        end
      end
      PH_CHECK: begin
        parse_phase = PH_HUNT1;
        if (b == parse_sum) begin
          // good frame: window insert and median of the held samples
          window_dist[window_slot] = {dist_hi, dist_lo};
          window_slot = (window_slot + 1 == WIN) ? 0 : window_slot + 1;
          if (window_fill < WIN) window_fill++;
          for (k = 0; k < window_fill; k++) sorted_q.push_back(int'(window_dist[k]));
          sorted_q.sort();
          if (window_fill % 2 == 1) median = 17'(2 * sorted_q[window_fill / 2]);
          else median = 17'(sorted_q[window_fill / 2 - 1] + sorted_q[window_fill / 2]);
          near = (median > 0) && (median <= 2 * threshold_cfg);
          if (!near) close_run_now = '0;
          else if (close_run_now != RUN_MAX) close_run_now++;
          if (close_run_now >= required_cfg) stopped = 1'b1;
          r.raw_distance     = {dist_hi, dist_lo};
          r.filtered_half_cm = median;
          r.close_flag       = near;
          r.close_run        = close_run_now;
          r.stop_latched     = stopped;
          r.pwm_duty         = stopped ? 8'd0 : duty_cfg;
          expected_readings.push_back(r);
        end
        parse_sum = '0;
      end
      default: begin
        if (parse_phase == PH_DIST_LO) dist_lo = b;
        if (parse_phase == PH_DIST_HI) dist_hi = b;
        parse_sum   = parse_sum + b;
        parse_phase = parse_phase + 1'b1;
      end
    endcase
  endtask

  // one input transaction, with random idle cycles ahead of it
  task automatic send_item(input logic op, input logic [7:0] b);
    while (!src_steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_items++;
    predict_reading(op, b);
  endtask

  // full nine byte frame, optionally with a corrupted checksum
  task automatic send_frame(input logic [15:0] distance, input bit bad_sum);
    logic [7:0] fb[9];
    logic [7:0] sum;
    int         k;
    fb[0] = HEADER_BYTE;
    fb[1] = HEADER_BYTE;
    fb[2] = distance[7:0];
    fb[3] = distance[15:8];
    for (k = 4; k < 8; k++) fb[k] = 8'($urandom);
    sum = '0;
    for (k = 0; k < 8; k++) sum = sum + fb[k];
    fb[8] = bad_sum ? sum + 8'($urandom_range(1, 255)) : sum;
    for (k = 0; k < 9; k++) send_item(OP_BYTE, fb[k]);
  endtask

  // keeps the stop from latching during the traffic phases
  task automatic guarded_frame(input logic [15:0] distance, input bit bad_sum);
    if (required_cfg > 1 && close_run_now + 1 >= required_cfg)
      send_item(OP_TIMEOUT, 8'($urandom));
    send_frame(distance, bad_sum);
  endtask

  function automatic logic [15:0] pick_distance();
    int sel;
    int top;
    sel = $urandom_range(0, 9);
    top = 2 * threshold_cfg + 1;
    if (top > 65535) top = 65535;
    case (sel)
      0:          return 16'd0;
      1:          return 16'hFFFF;
      2, 3, 4, 5: return 16'($urandom_range(0, top));
      default:    return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] non_header_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == HEADER_BYTE);
    return b;
  endfunction

  // register write, only while the unit is idle
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_THRESHOLD: threshold_cfg = val;
      REG_REQUIRED:  required_cfg  = val[3:0];
      REG_RUN_DUTY:  duty_cfg      = val[7:0];
      default: ;
    endcase
  endtask

  // drain all results, then let queued timeout clears finish
  task automatic quiesce();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [16:0] want,
                               input logic [16:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_reading(input logic [47:0] data);
    reading_t got;
    reading_t want;
    got = data[46:0];
    if (expected_readings.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result, expected none, actual %h", $time, data);
      return;
    end
    want = expected_readings.pop_front();
    compare_field("raw_distance", 17'(want.raw_distance), 17'(got.raw_distance));
    compare_field("filtered_half_cm", want.filtered_half_cm, got.filtered_half_cm);
    compare_field("close_flag", 17'(want.close_flag), 17'(got.close_flag));
    compare_field("close_run", 17'(want.close_run), 17'(got.close_run));
    compare_field("stop_latched", 17'(want.stop_latched), 17'(got.stop_latched));
    compare_field("pwm_duty", 17'(want.pwm_duty), 17'(got.pwm_duty));
  endtask

  // result side: random stalls and checking of each transaction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= sink_steady || ($urandom_range(0, 99) >= IDLE_PCT);
      if (m_tvalid && m_tready) check_reading(m_tdata);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // register defaults, frame right at the inclusive threshold
  task automatic test_reset_defaults();
    send_frame(16'd800, 1'b0);
  endtask

  // bad second header, timeout in mid frame, checksum mismatch
  task automatic test_framing_errors();
    send_item(OP_BYTE, HEADER_BYTE);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, HEADER_BYTE);
    send_item(OP_BYTE, HEADER_BYTE);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_TIMEOUT, 8'hFF);
    send_frame(16'd0, 1'b1);
  endtask

  // mostly well formed frames, with noise and broken sequences
  task automatic run_traffic_phase(input int n_items);
    int first;
    int pick;
    int k;
    int n;
    first = sent_items;
    while (sent_items - first < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        guarded_frame(pick_distance(), 1'b0);
      end else if (pick < 82) begin
        guarded_frame(pick_distance(), 1'b1);
      end else if (pick < 87) begin
        send_item(OP_TIMEOUT, 8'($urandom));
      end else if (pick < 91) begin
        send_item(OP_BYTE, HEADER_BYTE);
        send_item(OP_BYTE, non_header_byte());
      end else if (pick < 95) begin
        // truncated frame, usually cut off by a timeout
        send_item(OP_BYTE, HEADER_BYTE);
        send_item(OP_BYTE, HEADER_BYTE);
        n = $urandom_range(0, 5);
        for (k = 0; k < n; k++) send_item(OP_BYTE, 8'($urandom));
        if ($urandom_range(0, 3) != 0) send_item(OP_TIMEOUT, 8'($urandom));
      end else begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
          send_item(OP_BYTE, ($urandom_range(0, 3) == 0) ? HEADER_BYTE : 8'($urandom));
      end
    end
  endtask

  // several register settings, extremes first
  task automatic test_random_traffic();
    int p;
    for (p = 0; p < 5; p++) begin
      quiesce();
      case (p)
        0: begin
          write_reg(REG_THRESHOLD, 16'd0);
          write_reg(REG_REQUIRED, 16'd2);
          write_reg(REG_RUN_DUTY, 16'd255);
        end
        1: begin
          write_reg(REG_THRESHOLD, 16'hFFFF);
          write_reg(REG_REQUIRED, 16'd15);
          write_reg(REG_RUN_DUTY, 16'd0);
        end
        2: begin
          write_reg(REG_UNUSED, 16'($urandom));
          write_reg(REG_THRESHOLD, 16'($urandom_range(1, 2000)));
          write_reg(REG_REQUIRED, 16'($urandom_range(2, 15)));
          write_reg(REG_RUN_DUTY, 16'($urandom_range(0, 255)));
        end
        default: begin
          write_reg(REG_THRESHOLD, 16'($urandom));
          write_reg(REG_REQUIRED, 16'($urandom_range(2, 15)));
          write_reg(REG_RUN_DUTY, 16'($urandom_range(0, 255)));
        end
      endcase
      // one phase runs with no idle cycles on either side
      src_steady  = (p == 1);
      sink_steady = (p == 1);
      run_traffic_phase(PHASE_ITEMS);
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  // latch the stop, then everything after it is dropped
  task automatic test_stop_latch();
    int tries;
    quiesce();
    write_reg(REG_THRESHOLD, 16'hFFFF);
    write_reg(REG_REQUIRED, ($urandom_range(0, 1) == 0) ? 16'd0 : 16'd15);
    write_reg(REG_RUN_DUTY, 16'($urandom_range(1, 255)));
    send_item(OP_TIMEOUT, 8'($urandom));
    tries = 0;
    while (!stopped && tries < 40) begin
      send_frame(16'($urandom_range(1, 65535)), 1'b0);
      tries++;
    end
    send_frame(16'($urandom_range(1, 65535)), 1'b0);
    send_item(OP_TIMEOUT, 8'($urandom));
    send_frame(16'($urandom_range(1, 65535)), 1'b0);
  endtask

  // test sequence
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_framing_errors();
    test_random_traffic();
    test_stop_latch();
    quiesce();
    if (mismatches == 0 && expected_readings.size() == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/lmos_pkg.sv
rtl/core/lmos_parser.sv
rtl/core/lmos_queue.sv
rtl/core/lmos_median_back.sv
rtl/core/lidar_median_obstacle_stop_unit.sv
dv/tb_top.sv
